### sv/brp_pkg.sv
// Shared constants, types and helper functions for the bit width repacker.
package brp_pkg;

  localparam int unsigned ValueW     = 25;
  localparam int unsigned BufW       = 32;
  localparam int unsigned CountW     = 6;
  localparam int unsigned WidthW     = 5;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned LeftW      = 3;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 5;
  localparam int unsigned MinBits    = 8;
  localparam int unsigned MaxBits    = 25;
  localparam int unsigned ResetBits  = 21;

  typedef enum logic [CfgIdxW-1:0] {
    CfgValueBits = 1'b0,
    CfgDirection = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    DirUnpack = 1'b0,
    DirPack   = 1'b1
  } dir_e;

  // Everything the serializer needs to emit the results of one item.
  typedef struct packed {
    logic              load;
    logic [BufW-1:0]   word;
    logic [ValueW-1:0] value;
    logic [CountW-1:0] pos;
    logic [LeftW-1:0]  left;
  } load_t;

  function automatic logic [WidthW-1:0] clamp_width(input logic [WidthW-1:0] v);
    logic [WidthW-1:0] r;
    if (v < WidthW'(MinBits)) begin
      r = WidthW'(MinBits);
    end else if (v > WidthW'(MaxBits)) begin
      r = WidthW'(MaxBits);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [ValueW-1:0] width_mask(input logic [WidthW-1:0] n);
    logic [BufW-1:0] m;
    m = (BufW'(1) << n) - BufW'(1);
    return m[ValueW-1:0];
  endfunction

endpackage

### sv/brp_if.sv
// Valid/ready stream interfaces for the input items and the result items.
interface brp_in_if;
  logic                       valid;
  logic                       ready;
  logic [brp_pkg::ValueW-1:0] in_value;
  logic                       in_last;

  modport source (output valid, output in_value, output in_last, input ready);
  modport sink   (input valid, input in_value, input in_last, output ready);
endinterface

interface brp_out_if;
  logic                       valid;
  logic                       ready;
  logic [brp_pkg::ValueW-1:0] out_value;
  logic                       run_last;

  modport source (output valid, output out_value, output run_last, input ready);
  modport sink   (input valid, input out_value, input run_last, output ready);
endinterface

### sv/brp_accum.sv
// Bit buffer, configuration registers and per-item result computation.
module brp_accum (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [brp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [brp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_accept_i,
  input  logic [brp_pkg::ValueW-1:0]   in_value_i,
  input  logic                         in_last_i,
  output brp_pkg::load_t               load_o
);
  import brp_pkg::*;

  logic [WidthW-1:0] width_q, width_d;
  dir_e              dir_q, dir_d;
  logic [BufW-1:0]   buf_q, buf_d;
  logic [CountW-1:0] cnt_q, cnt_d;

  logic [ValueW-1:0] mask;
  logic [BufW-1:0]   ubuf, pbuf, ushift, pshift;
  logic [CountW-1:0] ucnt, urem, pcnt, ppos;
  logic              uhit;
  logic [LeftW-1:0]  pleft;

  always_comb begin
    mask   = width_mask(width_q);
    // unpack: append one byte, take N bits when enough have gathered
    ubuf   = {buf_q[BufW-ByteW-1:0], in_value_i[ByteW-1:0]};
    ucnt   = cnt_q + CountW'(ByteW);
    uhit   = ucnt >= CountW'(width_q);
    urem   = ucnt - CountW'(width_q);
    ushift = ubuf >> urem;
    // pack: append N bits, every whole byte leaves
    pbuf   = (buf_q << width_q) | BufW'(in_value_i & mask);
    pcnt   = cnt_q + CountW'(width_q);
    pleft  = pcnt[CountW-1:3];
    ppos   = pcnt - CountW'(ByteW);
    pshift = pbuf >> ppos;
  end

  always_comb begin
    load_o = '0;
    if (dir_q == DirUnpack) begin
      load_o.load  = in_accept_i && uhit;
      load_o.word  = ubuf;
      load_o.value = ushift[ValueW-1:0] & mask;
      load_o.pos   = urem;
      load_o.left  = LeftW'(1);
    end else begin
      load_o.load  = in_accept_i && (pleft != '0);
      load_o.word  = pbuf;
      load_o.value = ValueW'(pshift[ByteW-1:0]);
      load_o.pos   = ppos;
      load_o.left  = pleft;
    end
  end

  always_comb begin
    width_d = width_q;
    dir_d   = dir_q;
    buf_d   = buf_q;
    cnt_d   = cnt_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgValueBits: width_d = clamp_width(cfg_data_i[WidthW-1:0]);
        CfgDirection: dir_d   = dir_e'(cfg_data_i[0]);
        default:      width_d = width_q;
      endcase
      // any register write starts a fresh stream
      buf_d = '0;
      cnt_d = '0;
    end else if (in_accept_i) begin
      if (in_last_i) begin
        buf_d = '0;
        cnt_d = '0;
      end else if (dir_q == DirUnpack) begin
        buf_d = ubuf;
        cnt_d = uhit ? urem : ucnt;
      end else begin
        buf_d = pbuf;
        cnt_d = {3'd0, pcnt[2:0]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthW'(ResetBits);
      dir_q   <= DirUnpack;
      buf_q   <= '0;
      cnt_q   <= '0;
    end else begin
      width_q <= width_d;
      dir_q   <= dir_d;
      buf_q   <= buf_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### sv/brp_serializer.sv
// Result register that emits the one to four results of an item, one per transfer.
module brp_serializer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  brp_pkg::load_t             load_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [brp_pkg::ValueW-1:0] out_value_o,
  output logic                       run_last_o,
  output logic                       can_load_o
);
  import brp_pkg::*;

  logic              valid_q, valid_d;
  logic [LeftW-1:0]  left_q, left_d;
  logic [CountW-1:0] pos_q, pos_d;
  logic [BufW-1:0]   word_q, word_d;
  logic [ValueW-1:0] value_q, value_d;

  logic              take, final_res;
  logic [CountW-1:0] next_pos;
  logic [BufW-1:0]   next_shift;

  assign take        = valid_q && out_ready_i;
  assign final_res   = left_q == LeftW'(1);
  assign can_load_o  = !valid_q || (take && final_res);
  assign out_valid_o = valid_q;
  assign out_value_o = value_q;
  assign run_last_o  = final_res;

  always_comb begin
    next_pos   = pos_q - CountW'(ByteW);
    next_shift = word_q >> next_pos;
    valid_d    = valid_q;
    left_d     = left_q;
    pos_d      = pos_q;
    word_d     = word_q;
    value_d    = value_q;
    if (load_i.load) begin
      valid_d = 1'b1;
      left_d  = load_i.left;
      pos_d   = load_i.pos;
      word_d  = load_i.word;
      value_d = load_i.value;
    end else if (take) begin
      if (final_res) begin
        valid_d = 1'b0;
      end else begin
        // advance to the next byte of the stored word
        left_d  = left_q - LeftW'(1);
        pos_d   = next_pos;
        value_d = ValueW'(next_shift[ByteW-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      left_q  <= '0;
    end else begin
      valid_q <= valid_d;
      left_q  <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    word_q  <= word_d;
    value_q <= value_d;
  end

endmodule

### sv/bit_width_repacker_top.sv
// Top level of the bit width repacker: byte stream to N-bit values and back.
//
// Usage:
//   in_ch_i carries input items: a byte or an N-bit value in in_value, plus
//   in_last, which drops any leftover bits once the item is processed.
//   out_ch_o carries results: an unpacked N-bit value or a packed byte in the
//   low eight bits; run_last marks the final result of an input item.
//   The configuration port writes value_bits (index 0, clamped to 8..25) or
//   direction (index 1, 0 unpack, 1 pack); every write clears the bit buffer.
//   Write configuration only while no results are pending.
// Latency: the first result of an item is valid the cycle after its transfer.
// Output: when unpacking an item gives at most one result; packing gives one to
//   four bytes per item, which the single result register emits one byte per
//   transfer. A new item is taken in the cycle the last result of the previous
//   one is transferred.
// Reset: value_bits is 21, direction unpack, buffer empty, no result pending.
// Stall: while the receiver holds ready low the result register holds, and the
//   input is stalled only once that register is occupied.
module bit_width_repacker_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  brp_in_if.sink                       in_ch_i,
  brp_out_if.source                    out_ch_o,
  input  logic                         cfg_we_i,
  input  logic [brp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [brp_pkg::CfgDataW-1:0] cfg_data_i
);
  import brp_pkg::*;

  load_t load;
  logic  can_load;
  logic  accept;

  assign in_ch_i.ready = can_load;
  assign accept        = in_ch_i.valid && can_load;

  brp_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_accept_i (accept),
    .in_value_i  (in_ch_i.in_value),
    .in_last_i   (in_ch_i.in_last),
    .load_o      (load)
  );

  brp_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .out_ready_i (out_ch_o.ready),
    .out_valid_o (out_ch_o.valid),
    .out_value_o (out_ch_o.out_value),
    .run_last_o  (out_ch_o.run_last),
    .can_load_o  (can_load)
  );

endmodule

### sv/brp_checker.sv
// Port-level assertions for the bit width repacker, bound to its top level.
module brp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [brp_pkg::ValueW-1:0]   out_value_i,
  input logic                         run_last_i,
  input logic                         cfg_we_i,
  input logic [brp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input logic [brp_pkg::CfgDataW-1:0] cfg_data_i
);
  import brp_pkg::*;

  dir_e dir_q;

  // track the direction register as written through the port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DirUnpack;
    end else if (cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CfgDirection)) begin
      dir_q <= dir_e'(cfg_data_i[0]);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_value_i) && $stable(run_last_i))
    else $error("stalled result changed");

  a_ready_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result pending");

  a_unpack_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (dir_q == DirUnpack) |-> run_last_i)
    else $error("unpack produced more than one result for an item");

  a_pack_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (dir_q == DirPack) |-> (out_value_i[ValueW-1:ByteW] == '0))
    else $error("packed result wider than a byte");

endmodule

bind bit_width_repacker_top brp_checker u_brp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_ch_i.ready),
  .out_valid_i (out_ch_o.valid),
  .out_ready_i (out_ch_o.ready),
  .out_value_i (out_ch_o.out_value),
  .run_last_i  (out_ch_o.run_last),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_data_i  (cfg_data_i)
);
